[rtl/nsp_pkg.sv]
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the nearest segment pick unit.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned SlotBits  = 10;
  localparam int unsigned CfgBits   = 16;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_SEGS_USED = 1'b1;

  typedef struct packed {
    logic                        operation;
    logic [SlotBits-1:0]         slot;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
  } nsp_in_t;

  typedef struct packed {
    logic                found;
    logic [SlotBits-1:0] nearest_slot;
  } nsp_out_t;

  // datapath micro-operations, one per controller step
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_TOLSQ,
    UOP_TOLLD,
    UOP_FETCH,
    UOP_DIFF,
    UOP_DXDX,
    UOP_DYDY,
    UOP_DXVX,
    UOP_DYVY,
    UOP_DXVY,
    UOP_DYVX,
    UOP_VXVX,
    UOP_VYVY,
    UOP_WXWX,
    UOP_WYWY,
    UOP_CRCR,
    UOP_SEL,
    UOP_NLO,
    UOP_NHI,
    UOP_BLO,
    UOP_BHI,
    UOP_CMP
  } uop_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TOLSQ,
    ST_TOLLD,
    ST_FETCH,
    ST_DIFF,
    ST_DXDX,
    ST_DYDY,
    ST_DXVX,
    ST_DYVY,
    ST_DXVY,
    ST_DYVX,
    ST_VXVX,
    ST_VYVY,
    ST_WXWX,
    ST_WYWY,
    ST_CRCR,
    ST_SEL,
    ST_NLO,
    ST_NHI,
    ST_BLO,
    ST_BHI,
    ST_CMP,
    ST_RESULT
  } ctl_state_e;

  typedef struct packed {
    uop_e uop;
    logic capture;   // latch query point and segment count
    logic load_wr;   // write load request into the table
    logic out_load;  // move result into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/nsp_ram.sv]
// ----------------------------------------------------------------------------
// nsp_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/nsp_ctrl.sv]
// ----------------------------------------------------------------------------
// nsp_ctrl
// Step sequencer: walks each segment through the shared multiplier.
// ----------------------------------------------------------------------------
module nsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  input  nsp_pkg::dp_stat_t  stat_i,
  output nsp_pkg::ctl_cmd_t  cmd_o
);
  import nsp_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.uop     = UOP_NONE;
    cmd_o.capture = 1'b0;
    cmd_o.load_wr = 1'b0;
    cmd_o.out_load = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_TOLSQ;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_TOLSQ: begin cmd_o.uop = UOP_TOLSQ; state_d = ST_TOLLD; end
      ST_TOLLD: begin
        cmd_o.uop = UOP_TOLLD;
        state_d   = stat_i.n_zero ? ST_RESULT : ST_FETCH;
      end
      ST_FETCH: begin cmd_o.uop = UOP_FETCH; state_d = ST_DIFF; end
      ST_DIFF:  begin cmd_o.uop = UOP_DIFF;  state_d = ST_DXDX; end
      ST_DXDX:  begin cmd_o.uop = UOP_DXDX;  state_d = ST_DYDY; end
      ST_DYDY:  begin cmd_o.uop = UOP_DYDY;  state_d = ST_DXVX; end
      ST_DXVX:  begin cmd_o.uop = UOP_DXVX;  state_d = ST_DYVY; end
      ST_DYVY:  begin cmd_o.uop = UOP_DYVY;  state_d = ST_DXVY; end
      ST_DXVY:  begin cmd_o.uop = UOP_DXVY;  state_d = ST_DYVX; end
      ST_DYVX:  begin cmd_o.uop = UOP_DYVX;  state_d = ST_VXVX; end
      ST_VXVX:  begin cmd_o.uop = UOP_VXVX;  state_d = ST_VYVY; end
      ST_VYVY:  begin cmd_o.uop = UOP_VYVY;  state_d = ST_WXWX; end
      ST_WXWX:  begin cmd_o.uop = UOP_WXWX;  state_d = ST_WYWY; end
      ST_WYWY:  begin cmd_o.uop = UOP_WYWY;  state_d = ST_CRCR; end
      ST_CRCR:  begin cmd_o.uop = UOP_CRCR;  state_d = ST_SEL;  end
      ST_SEL:   begin cmd_o.uop = UOP_SEL;   state_d = ST_NLO;  end
      ST_NLO:   begin cmd_o.uop = UOP_NLO;   state_d = ST_NHI;  end
      ST_NHI:   begin cmd_o.uop = UOP_NHI;   state_d = ST_BLO;  end
      ST_BLO:   begin cmd_o.uop = UOP_BLO;   state_d = ST_BHI;  end
      ST_BHI:   begin cmd_o.uop = UOP_BHI;   state_d = ST_CMP;  end
      ST_CMP: begin
        cmd_o.uop = UOP_CMP;
        state_d   = stat_i.idx_last ? ST_RESULT : ST_FETCH;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/nsp_dpath.sv]
// ----------------------------------------------------------------------------
// nsp_dpath
// Segment table, shared 35x35 multiplier, exact distance compare, result reg.
// ----------------------------------------------------------------------------
module nsp_dpath #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nsp_pkg::ctl_cmd_t          cmd_i,
  output nsp_pkg::dp_stat_t          stat_o,
  input  nsp_pkg::nsp_in_t           in_req_i,
  input  logic [15:0]                tolerance_i,
  input  logic [10:0]                seg_used_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output nsp_pkg::nsp_out_t          out_req_o
);
  import nsp_pkg::*;

  localparam int unsigned AW = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TW = 4 * CoordBits;

  // table
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data, rd_data;
  logic [AW-1:0] rd_addr;

  // control state
  logic [IW-1:0] idx_q, n_q;
  logic          found_q;
  logic          out_valid_q;

  // payload
  logic signed [CoordBits-1:0] px_q, py_q;
  logic signed [16:0] dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] p_q;
  logic [33:0]        len2_q, vv_q, ww_q;
  logic signed [34:0] dot_q, cr_q;
  logic [65:0]        num_q, bnum_q;
  logic [33:0]        den_q, bden_q;
  logic               seg_ok_q;
  logic [99:0]        lhs_q, rhs_q, rhs_full, p_lo, p_hi;
  logic [AW-1:0]      pick_q;
  nsp_out_t           out_q;

  logic signed [CoordBits-1:0] sx, sy, ex, ey;

  assign wr_en   = cmd_i.load_wr && (32'(in_req_i.slot) < 32'(MAX_SEGMENTS));
  assign wr_addr = AW'(in_req_i.slot);
  assign wr_data = {in_req_i.end_y, in_req_i.end_x, in_req_i.start_y, in_req_i.start_x};
  assign rd_addr = idx_q[AW-1:0];

  nsp_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign sx = rd_data[15:0];
  assign sy = rd_data[31:16];
  assign ex = rd_data[47:32];
  assign ey = rd_data[63:48];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.uop)
      UOP_TOLSQ: begin mul_a = {19'b0, tolerance_i}; mul_b = {19'b0, tolerance_i}; end
      UOP_DXDX:  begin mul_a = 35'(dx_q); mul_b = 35'(dx_q); end
      UOP_DYDY:  begin mul_a = 35'(dy_q); mul_b = 35'(dy_q); end
      UOP_DXVX:  begin mul_a = 35'(dx_q); mul_b = 35'(vx_q); end
      UOP_DYVY:  begin mul_a = 35'(dy_q); mul_b = 35'(vy_q); end
      UOP_DXVY:  begin mul_a = 35'(dx_q); mul_b = 35'(vy_q); end
      UOP_DYVX:  begin mul_a = 35'(dy_q); mul_b = 35'(vx_q); end
      UOP_VXVX:  begin mul_a = 35'(vx_q); mul_b = 35'(vx_q); end
      UOP_VYVY:  begin mul_a = 35'(vy_q); mul_b = 35'(vy_q); end
      UOP_WXWX:  begin mul_a = 35'(wx_q); mul_b = 35'(wx_q); end
      UOP_WYWY:  begin mul_a = 35'(wy_q); mul_b = 35'(wy_q); end
      UOP_CRCR:  begin mul_a = cr_q; mul_b = cr_q; end
      UOP_NLO:   begin mul_a = {2'b0, num_q[32:0]};  mul_b = {1'b0, bden_q}; end
      UOP_NHI:   begin mul_a = {2'b0, num_q[65:33]}; mul_b = {1'b0, bden_q}; end
      UOP_BLO:   begin mul_a = {2'b0, bnum_q[32:0]};  mul_b = {1'b0, den_q}; end
      UOP_BHI:   begin mul_a = {2'b0, bnum_q[65:33]}; mul_b = {1'b0, den_q}; end
      default: ;
    endcase
  end

  // partial products are non-negative in the compare steps
  assign p_lo     = 100'(p_q[66:0]);
  assign p_hi     = p_lo << 33;
  assign rhs_full = rhs_q + p_hi;

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      px_q <= in_req_i.point_x;
      py_q <= in_req_i.point_y;
    end
    case (cmd_i.uop)
      UOP_TOLLD: begin
        bnum_q <= 66'(p_q[31:0]);
        bden_q <= 34'd1;
      end
      UOP_DIFF: begin
        dx_q <= {ex[15], ex} - {sx[15], sx};
        dy_q <= {ey[15], ey} - {sy[15], sy};
        vx_q <= {px_q[15], px_q} - {sx[15], sx};
        vy_q <= {py_q[15], py_q} - {sy[15], sy};
        wx_q <= {px_q[15], px_q} - {ex[15], ex};
        wy_q <= {py_q[15], py_q} - {ey[15], ey};
      end
      UOP_DYDY: len2_q <= p_q[33:0];
      UOP_DXVX: len2_q <= len2_q + p_q[33:0];
      UOP_DYVY: dot_q  <= p_q[34:0];
      UOP_DXVY: dot_q  <= dot_q + p_q[34:0];
      UOP_DYVX: cr_q   <= p_q[34:0];
      UOP_VXVX: cr_q   <= cr_q - p_q[34:0];
      UOP_VYVY: vv_q   <= p_q[33:0];
      UOP_WXWX: vv_q   <= vv_q + p_q[33:0];
      UOP_WYWY: ww_q   <= p_q[33:0];
      UOP_CRCR: ww_q   <= ww_q + p_q[33:0];
      UOP_SEL: begin
        // zero-length segments never qualify
        seg_ok_q <= (len2_q != '0);
        if (dot_q < 0) begin
          num_q <= 66'(vv_q);
          den_q <= 34'd1;
        end else if (dot_q[33:0] > len2_q) begin
          num_q <= 66'(ww_q);
          den_q <= 34'd1;
        end else begin
          num_q <= p_q[65:0];
          den_q <= len2_q;
        end
      end
      UOP_NHI: lhs_q <= p_lo;
      UOP_BLO: lhs_q <= lhs_q + p_hi;
      UOP_BHI: rhs_q <= p_lo;
      UOP_CMP: begin
        if (seg_ok_q && (lhs_q < rhs_full)) begin
          bnum_q <= num_q;
          bden_q <= den_q;
        end
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q.found        <= found_q;
      out_q.nearest_slot <= found_q ? SlotBits'(pick_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        pick_q  <= '0;
        n_q     <= (32'(seg_used_i) > 32'(MAX_SEGMENTS)) ? IW'(MAX_SEGMENTS)
                                                         : IW'(seg_used_i);
      end
      if (cmd_i.uop == UOP_CMP) begin
        idx_q <= idx_q + IW'(1);
        if (seg_ok_q && (lhs_q < rhs_full)) begin
          found_q <= 1'b1;
          pick_q  <= idx_q[AW-1:0];
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.n_zero   = (n_q == '0);
  assign stat_o.idx_last = (idx_q == n_q - IW'(1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[rtl/nearest_segment_pick_unit.sv]
// ----------------------------------------------------------------------------
// nearest_segment_pick_unit
// Segment table with a nearest-segment search against a query point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_req_i): a load request writes a
//    segment into a table slot (slots at or past MAX_SEGMENTS are dropped);
//    a query searches slots 0..min(segments_in_use, MAX_SEGMENTS)-1 for the
//    closest segment strictly inside the tolerance and returns one result.
//  - Output channel (out_valid_o/out_ready_i/out_req_o): one result per
//    query, none per load. Ties go to the lower slot.
//  - Config port: cfg_we_i writes tolerance (index 0) or segments_in_use
//    (index 1) at once; write only while the unit is idle.
//  - Steps: a load is written to the table when taken. A query squares the
//    tolerance, then per searched slot: a table read, a difference step,
//    15 passes through the one shared 35x35 multiplier, a select, a compare.
//  - One request is worked at a time; in_ready_o is low during a search.
//  - The result sits in an output register: a new request is taken while it
//    waits. A stalled receiver holds a finished query until the register
//    frees up.
//  - Reset clears control state and sets tolerance to 80 and the slot count
//    to 0. Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_segment_pick_unit #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nsp_pkg::nsp_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nsp_pkg::nsp_out_t out_req_o,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [15:0]      cfg_wdata_i
);
  import nsp_pkg::*;

  logic [15:0] tolerance_q;
  logic [10:0] seg_used_q;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= 16'd80;
      seg_used_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TOLERANCE: tolerance_q <= cfg_wdata_i;
        CFG_SEGS_USED: seg_used_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  nsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_req_i.operation),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nsp_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .tolerance_i (tolerance_q),
    .seg_used_i  (seg_used_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  // a query request starts a search, so the input side closes
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.operation == OP_QUERY) |=> !in_ready_o)
    else $error("input still ready after query request");

  // a load request does not stall the unit: the input stays ready
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.operation == OP_LOAD) |=> in_ready_o)
    else $error("load request stalled the unit");

  // a miss reports slot zero
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.found) |-> (out_req_o.nearest_slot == '0))
    else $error("miss with nonzero slot");
`endif

endmodule
